>>> sv/pcid_pkg.sv
// ----------------------------------------------------------------------------
// pcid_pkg
// Shared types and constants for the polyhedron centroid / inner distance block.
// ----------------------------------------------------------------------------
package pcid_pkg;

  localparam int COORD_W   = 12;
  localparam int FRAC_BITS = 4;
  localparam int OUT_FRAC  = 16;
  localparam int CEN_SH    = OUT_FRAC - 2 - FRAC_BITS;
  localparam int CEN_W     = 28;
  localparam int DIST_W    = 29;
  localparam int DIV_DW    = 74;
  localparam int DIV_LW    = 29;

  localparam logic [DIV_LW-1:0] DIST_MAX = {DIV_LW{1'b1}};
  localparam logic [DIV_LW-1:0] CEN_MAX  = DIV_LW'((64'd1 << (CEN_W - 1)) - 64'd1);
  localparam logic [DIV_LW-1:0] CEN_MIN_MAG = DIV_LW'(64'd1 << (CEN_W - 1));

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t az;
    coord_t bx;
    coord_t by_coord;
    coord_t bz;
    coord_t cx_in;
    coord_t cy_in;
    coord_t cz_in;
    logic   last_face;
  } in_item_t;

  typedef struct packed {
    logic signed [CEN_W-1:0] centroid_x;
    logic signed [CEN_W-1:0] centroid_y;
    logic signed [CEN_W-1:0] centroid_z;
    logic [DIST_W-1:0]       min_distance;
    logic                    degenerate;
    logic                    overflowed;
  } out_item_t;

  // one stored face, three vertices of x/y/z
  typedef struct packed {
    coord_t [2:0] a;
    coord_t [2:0] b;
    coord_t [2:0] c;
  } face_t;

  typedef struct packed {
    logic              start;
    logic [DIV_DW-1:0] dividend;
    logic [63:0]       divisor;
    logic [DIV_LW-1:0] limit;
  } div_req_t;

endpackage

>>> sv/polyhedron_centroid_inner_distance.sv
// ----------------------------------------------------------------------------
// polyhedron_centroid_inner_distance
// Centroid of a closed triangulated polyhedron and least centroid-to-face distance.
// ----------------------------------------------------------------------------
// Each stored face steps through cross, volume and weighted sum while busy is high.
// Unless the volume is zero, the last face adds 3 serial divides (one quotient bit a cycle)
// plus a walk over each stored face: read, edges, normal, dot, square root, divide (skipped if zero-area).
// One result strobe per polyhedron; the receiver cannot stall it.
// Reset clears control and sums; the face memory is not cleared (no clearing pass).
module polyhedron_centroid_inner_distance #(
  parameter int MAX_FACES = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  pcid_pkg::in_item_t   in_data,
  output logic                 out_valid,
  output pcid_pkg::out_item_t  out_data
);
  import pcid_pkg::*;

  localparam int AW = $clog2(MAX_FACES);
  localparam int CW = $clog2(MAX_FACES + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CROSS = 4'd1;
  localparam logic [3:0] S_VOL   = 4'd2;
  localparam logic [3:0] S_WSUM  = 4'd3;
  localparam logic [3:0] S_FIN   = 4'd4;
  localparam logic [3:0] S_CEN   = 4'd5;
  localparam logic [3:0] S_CENW  = 4'd6;
  localparam logic [3:0] S_RD    = 4'd7;
  localparam logic [3:0] S_W1    = 4'd8;
  localparam logic [3:0] S_W2    = 4'd9;
  localparam logic [3:0] S_W3    = 4'd10;
  localparam logic [3:0] S_SQ    = 4'd11;
  localparam logic [3:0] S_SQW   = 4'd12;
  localparam logic [3:0] S_DVW   = 4'd13;

  logic [3:0]  state_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] f_r;
  logic [1:0]  kidx_r;
  logic        oflow_r;
  logic        last_r;
  logic signed [63:0] vol_r;
  logic signed [63:0] w_r [3];
  logic        out_valid_r;
  out_item_t   out_data_r;

  coord_t                  apex_r [3];
  logic signed [12:0]      e1_r [3];
  logic signed [12:0]      e2_r [3];
  logic signed [28:0]      d_r [3];
  logic signed [13:0]      s_r [3];
  logic signed [26:0]      n_r [3];
  logic signed [42:0]      v_r;
  logic signed [57:0]      dot_r;
  logic [55:0]             nn_r;
  logic signed [CEN_W-1:0] cen_r [3];
  logic [DIST_W-1:0]       best_r;

  coord_t pa [3], pb [3], pc [3], apx [3];
  coord_t fa [3], fb [3], fc [3];
  face_t  wface, rface;
  logic   accept, full;

  logic signed [25:0] pr [6];
  logic signed [26:0] n_c [3];
  logic signed [55:0] pdn [3];
  logic signed [57:0] dn_c;
  logic signed [53:0] pnn [3];
  logic [55:0]        nn_c;
  logic signed [56:0] ps [3];

  logic [63:0] wm, vm;
  logic        cneg;
  logic [57:0] dm;

  div_req_t          dreq;
  logic              div_done;
  logic [DIV_LW-1:0] div_q;
  logic              sq_start, sq_done;
  logic [31:0]       sq_root;

  assign pa[0] = in_data.ax;    assign pa[1] = in_data.ay;       assign pa[2] = in_data.az;
  assign pb[0] = in_data.bx;    assign pb[1] = in_data.by_coord; assign pb[2] = in_data.bz;
  assign pc[0] = in_data.cx_in; assign pc[1] = in_data.cy_in;    assign pc[2] = in_data.cz_in;

  assign busy   = state_r != S_IDLE;
  assign accept = start && !busy;
  assign full   = count_r == CW'(MAX_FACES);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      apx[k]      = (count_r == '0) ? pa[k] : apex_r[k];
      wface.a[k]  = pa[k];
      wface.b[k]  = pb[k];
      wface.c[k]  = pc[k];
      fa[k]       = rface.a[k];
      fb[k]       = rface.b[k];
      fc[k]       = rface.c[k];
    end
  end

  pcid_ram #(.WIDTH($bits(face_t)), .DEPTH(MAX_FACES)) u_face_ram (
    .clk   (clk),
    .we    (accept && !full),
    .waddr (count_r[AW-1:0]),
    .wdata (wface),
    .raddr (f_r[AW-1:0]),
    .rdata (rface)
  );

  // shared arithmetic
  always_comb begin
    pr[0] = e1_r[1] * e2_r[2];
    pr[1] = e1_r[2] * e2_r[1];
    pr[2] = e1_r[2] * e2_r[0];
    pr[3] = e1_r[0] * e2_r[2];
    pr[4] = e1_r[0] * e2_r[1];
    pr[5] = e1_r[1] * e2_r[0];
    for (int k = 0; k < 3; k++) begin
      n_c[k] = 27'(pr[2*k]) - 27'(pr[2*k+1]);
      pdn[k] = d_r[k] * n_r[k];
      pnn[k] = n_r[k] * n_r[k];
      ps[k]  = s_r[k] * v_r;
    end
    dn_c = 58'(pdn[0]) + 58'(pdn[1]) + 58'(pdn[2]);
    nn_c = 56'($unsigned(pnn[0])) + 56'($unsigned(pnn[1])) + 56'($unsigned(pnn[2]));
  end

  always_comb begin
    wm   = w_r[kidx_r][63] ? (64'd0 - $unsigned(w_r[kidx_r])) : $unsigned(w_r[kidx_r]);
    vm   = vol_r[63] ? (64'd0 - $unsigned(vol_r)) : $unsigned(vol_r);
    cneg = w_r[kidx_r][63] ^ vol_r[63];
    dm   = dot_r[57] ? (58'd0 - $unsigned(dot_r)) : $unsigned(dot_r);
    dreq.start = (state_r == S_CEN) || ((state_r == S_SQW) && sq_done && (sq_root != '0));
    if (state_r == S_CEN) begin
      dreq.dividend = DIV_DW'({wm, CEN_SH'(0)});
      dreq.divisor  = vm;
      dreq.limit    = cneg ? CEN_MIN_MAG : CEN_MAX;
    end else begin
      dreq.dividend = DIV_DW'({dm, 3'b000});
      dreq.divisor  = 64'(sq_root);
      dreq.limit    = DIST_MAX;
    end
  end

  assign sq_start = state_r == S_SQ;

  pcid_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .done  (div_done),
    .quot  (div_q)
  );

  pcid_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (64'({nn_r, 6'b000000})),
    .done     (sq_done),
    .root     (sq_root)
  );

  // control, sums and result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      f_r         <= '0;
      kidx_r      <= '0;
      oflow_r     <= 1'b0;
      vol_r       <= '0;
      for (int k = 0; k < 3; k++) w_r[k] <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (full) begin
              oflow_r <= 1'b1;
              if (in_data.last_face) state_r <= S_FIN;
            end else begin
              state_r <= S_CROSS;
            end
          end
        end
        S_CROSS: state_r <= S_VOL;
        S_VOL: begin
          vol_r   <= vol_r + 64'(-dn_c);
          state_r <= S_WSUM;
        end
        S_WSUM: begin
          for (int k = 0; k < 3; k++) w_r[k] <= w_r[k] + 64'(ps[k]);
          count_r <= count_r + 1'b1;
          state_r <= last_r ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          if (vol_r == '0) begin
            out_valid_r <= 1'b1;
            count_r     <= '0;
            oflow_r     <= 1'b0;
            vol_r       <= '0;
            for (int k = 0; k < 3; k++) w_r[k] <= '0;
            state_r     <= S_IDLE;
          end else begin
            kidx_r  <= '0;
            state_r <= S_CEN;
          end
        end
        S_CEN: state_r <= S_CENW;
        S_CENW: begin
          if (div_done) begin
            if (kidx_r == 2'd2) begin
              f_r     <= '0;
              state_r <= S_RD;
            end else begin
              kidx_r  <= kidx_r + 1'b1;
              state_r <= S_CEN;
            end
          end
        end
        S_RD: begin
          if (f_r == count_r) begin
            out_valid_r <= 1'b1;
            count_r     <= '0;
            oflow_r     <= 1'b0;
            vol_r       <= '0;
            for (int k = 0; k < 3; k++) w_r[k] <= '0;
            state_r     <= S_IDLE;
          end else begin
            state_r <= S_W1;
          end
        end
        S_W1: state_r <= S_W2;
        S_W2: state_r <= S_W3;
        S_W3: state_r <= S_SQ;
        S_SQ: state_r <= S_SQW;
        S_SQW: begin
          if (sq_done) begin
            if (sq_root == '0) begin
              // zero-area face: no plane
              f_r     <= f_r + 1'b1;
              state_r <= S_RD;
            end else begin
              state_r <= S_DVW;
            end
          end
        end
        S_DVW: begin
          if (div_done) begin
            f_r     <= f_r + 1'b1;
            state_r <= S_RD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          last_r <= in_data.last_face;
          for (int k = 0; k < 3; k++) begin
            if (count_r == '0) apex_r[k] <= pa[k];
            e1_r[k] <= 13'(pb[k]) - 13'(pa[k]);
            e2_r[k] <= 13'(pc[k]) - 13'(pa[k]);
            d_r[k]  <= 29'(13'(apx[k]) - 13'(pa[k]));
            s_r[k]  <= 14'(pa[k]) + 14'(pb[k]) + 14'(pc[k]) + 14'(apx[k]);
          end
        end
      end
      S_CROSS: begin
        for (int k = 0; k < 3; k++) n_r[k] <= n_c[k];
      end
      S_VOL: v_r <= 43'(-dn_c);
      S_CENW: begin
        if (div_done) begin
          cen_r[kidx_r] <= cneg ? -CEN_W'(div_q) : CEN_W'(div_q);
          if (kidx_r == 2'd2) best_r <= DIST_MAX;
        end
      end
      S_FIN, S_RD: begin
        out_data_r.degenerate <= vol_r == '0;
        out_data_r.overflowed <= oflow_r;
        if (vol_r == '0) begin
          out_data_r.centroid_x   <= '0;
          out_data_r.centroid_y   <= '0;
          out_data_r.centroid_z   <= '0;
          out_data_r.min_distance <= '0;
        end else begin
          out_data_r.centroid_x   <= cen_r[0];
          out_data_r.centroid_y   <= cen_r[1];
          out_data_r.centroid_z   <= cen_r[2];
          out_data_r.min_distance <= best_r;
        end
      end
      S_W1: begin
        for (int k = 0; k < 3; k++) begin
          e1_r[k] <= 13'(fb[k]) - 13'(fa[k]);
          e2_r[k] <= 13'(fc[k]) - 13'(fa[k]);
          d_r[k]  <= 29'(cen_r[k]) - 29'($signed({fa[k], 12'h000}));
        end
      end
      S_W2: begin
        for (int k = 0; k < 3; k++) n_r[k] <= n_c[k];
      end
      S_W3: begin
        dot_r <= dn_c;
        nn_r  <= nn_c;
      end
      S_DVW: begin
        if (div_done && (div_q < best_r)) best_r <= div_q;
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_FACES)) else $error("face count past capacity");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.degenerate) |-> (out_data.centroid_x == '0 &&
      out_data.centroid_y == '0 && out_data.centroid_z == '0 &&
      out_data.min_distance == '0)) else $error("degenerate result not zero");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_CENW || state_r == S_DVW))
    else $error("divider finished with no waiting state");

endmodule

>>> sv/pcid_ram.sv
// ----------------------------------------------------------------------------
// pcid_ram
// Generic single write port / single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pcid_ram #(
  parameter int WIDTH = 108,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/pcid_div.sv
// ----------------------------------------------------------------------------
// pcid_div
// Restoring divider, one quotient bit per cycle, result clamped to a limit.
// ----------------------------------------------------------------------------
module pcid_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pcid_pkg::div_req_t               req,
  output logic                             done,
  output logic [pcid_pkg::DIV_LW-1:0]      quot
);
  import pcid_pkg::*;

  localparam int CNT_W = $clog2(DIV_DW);

  logic              run_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [63:0]       rem_r;
  logic [DIV_DW-1:0] dvd_r;
  logic [63:0]       dvs_r;
  logic [DIV_LW-1:0] lim_r;
  logic [DIV_LW:0]   q_r;
  logic              sticky_r;

  logic [64:0] rs;
  logic        ge;
  logic [64:0] rem_nxt;

  always_comb begin
    rs      = {rem_r, dvd_r[DIV_DW-1]};
    ge      = rs >= {1'b0, dvs_r};
    rem_nxt = ge ? (rs - {1'b0, dvs_r}) : rs;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(DIV_DW - 1);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder stays below the divisor, so 64 bits hold it
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r    <= '0;
      dvd_r    <= req.dividend;
      dvs_r    <= req.divisor;
      lim_r    <= req.limit;
      q_r      <= '0;
      sticky_r <= 1'b0;
    end else if (run_r) begin
      rem_r    <= rem_nxt[63:0];
      dvd_r    <= dvd_r << 1;
      q_r      <= {q_r[DIV_LW-1:0], ge};
      sticky_r <= sticky_r | q_r[DIV_LW];
    end
  end

  assign done = done_r;
  assign quot = (sticky_r || (q_r > {1'b0, lim_r})) ? lim_r : q_r[DIV_LW-1:0];

endmodule

>>> sv/pcid_isqrt.sv
// ----------------------------------------------------------------------------
// pcid_isqrt
// Integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module pcid_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic        run_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [63:0] x_r;
  logic [63:0] res_r;
  logic [63:0] bit_r;

  logic [63:0] trial;
  logic        ge;

  assign trial = res_r + bit_r;
  assign ge    = x_r >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= 5'd31;
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= radicand;
      res_r <= '0;
      bit_r <= 64'd1 << 62;
    end else if (run_r) begin
      if (ge) begin
        x_r   <= x_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = res_r[31:0];

endmodule
